@@ design/m3inv_pkg.sv @@
package m3inv_pkg;

    // Element width is fixed by the payload structs below.
    localparam int ELEM_WIDTH    = 32;
    localparam int FRAC_BITS_DEF = 16;

    // Cofactor k (already transposed) = e[p]*e[q] - e[r]*e[s], elements in row-major order.
    localparam int COF_IDX [9][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    typedef struct packed {
        logic signed [ELEM_WIDTH-1:0] a00;
        logic signed [ELEM_WIDTH-1:0] a01;
        logic signed [ELEM_WIDTH-1:0] a02;
        logic signed [ELEM_WIDTH-1:0] a10;
        logic signed [ELEM_WIDTH-1:0] a11;
        logic signed [ELEM_WIDTH-1:0] a12;
        logic signed [ELEM_WIDTH-1:0] a20;
        logic signed [ELEM_WIDTH-1:0] a21;
        logic signed [ELEM_WIDTH-1:0] a22;
    } t_matrix_in;

    typedef struct packed {
        logic signed [ELEM_WIDTH-1:0] b00;
        logic signed [ELEM_WIDTH-1:0] b01;
        logic signed [ELEM_WIDTH-1:0] b02;
        logic signed [ELEM_WIDTH-1:0] b10;
        logic signed [ELEM_WIDTH-1:0] b11;
        logic signed [ELEM_WIDTH-1:0] b12;
        logic signed [ELEM_WIDTH-1:0] b20;
        logic signed [ELEM_WIDTH-1:0] b21;
        logic signed [ELEM_WIDTH-1:0] b22;
        logic                         singular;
    } t_matrix_out;

endpackage

@@ design/m3inv_div.sv @@
module m3inv_div
    import m3inv_pkg::*;
#(
    parameter int QW = ELEM_WIDTH,
    parameter int CW = 4 * ELEM_WIDTH
) (
    input  logic          i_clk,
    input  logic [CW-1:0] i_num,
    input  logic [CW-1:0] i_den,
    output logic [QW-1:0] o_q,
    output logic          o_big
);

    // Restoring division, one quotient bit per stage, most significant first.
    // The first stage flags quotients that do not fit in QW bits.
    logic [CW-1:0] r_rem [QW];
    logic [CW-1:0] r_den [QW];
    logic [QW-1:0] r_q   [QW+1];
    logic          r_big [QW+1];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num;
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_big[0] <= i_num >= (i_den << QW);
    end

    for (genvar j = 1; j <= QW; j++) begin : g_stage
        logic [CW-1:0] w_sub;
        logic          w_ge;

        assign w_sub = r_den[j-1] << (QW - j);
        assign w_ge  = r_rem[j-1] >= w_sub;

        always_ff @(posedge i_clk) begin
            r_q[j]   <= {r_q[j-1][QW-2:0], w_ge};
            r_big[j] <= r_big[j-1];
        end

        if (j < QW) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[j] <= w_ge ? (r_rem[j-1] - w_sub) : r_rem[j-1];
                r_den[j] <= r_den[j-1];
            end
        end
    end

    assign o_q   = r_q[QW];
    assign o_big = r_big[QW];

endmodule

@@ design/matrix3_inverse_core.sv @@
// Fully pipelined 3x3 inverse: one matrix may be started in every clock cycle, busy stays low.
// The pipeline depth is set mostly by the nine bit-per-stage dividers that run side by side.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Synchronous active-low reset clears only the valid bits; data registers are not reset.
module matrix3_inverse_core
    import m3inv_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_matrix_in  i_matrix,
    output logic        o_valid,
    output t_matrix_out o_result
);

    localparam int E   = ELEM_WIDTH;
    localparam int PW  = 2 * E;                  // product of two elements
    localparam int CFW = 2 * E + 1;              // cofactor
    localparam int LW  = 2 * E + 1;              // partial product element x cofactor half
    localparam int DW  = 3 * E + 2;              // determinant
    localparam int NW  = 2 * E + 2 * FRAC_BITS + 1;
    localparam int CW  = ((NW > DW + E) ? NW : DW + E) + 1;
    localparam int LAT = E + 9;

    // The pipeline never stalls, so a new matrix is taken on any cycle.
    assign busy = 1'b0;

    // Valid bits march alongside the data, one per stage.
    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    assign o_valid = r_vld[LAT-1];

    // Stage 1: capture the matrix as an indexed array in row-major order.
    logic signed [E-1:0] r_e [9];

    always_ff @(posedge i_clk) begin
        r_e[0] <= i_matrix.a00;
        r_e[1] <= i_matrix.a01;
        r_e[2] <= i_matrix.a02;
        r_e[3] <= i_matrix.a10;
        r_e[4] <= i_matrix.a11;
        r_e[5] <= i_matrix.a12;
        r_e[6] <= i_matrix.a20;
        r_e[7] <= i_matrix.a21;
        r_e[8] <= i_matrix.a22;
    end

    // Stage 2: the eighteen two-element products. The first row is carried
    // along because the determinant needs it after the cofactors exist.
    logic signed [PW-1:0] r_pa [9];
    logic signed [PW-1:0] r_pb [9];
    logic signed [E-1:0]  r_row2 [3];
    logic signed [E-1:0]  r_row3 [3];

    for (genvar k = 0; k < 9; k++) begin : g_prod
        always_ff @(posedge i_clk) begin
            r_pa[k] <= PW'(r_e[COF_IDX[k][0]]) * PW'(r_e[COF_IDX[k][1]]);
            r_pb[k] <= PW'(r_e[COF_IDX[k][2]]) * PW'(r_e[COF_IDX[k][3]]);
        end
    end

    // Stage 3: cofactors, exact at twice the fraction scale.
    logic signed [CFW-1:0] r_cof3 [9];
    logic signed [CFW-1:0] r_cof4 [9];
    logic signed [CFW-1:0] r_cof5 [9];
    logic signed [CFW-1:0] r_cof6 [9];

    for (genvar k = 0; k < 9; k++) begin : g_cof
        always_ff @(posedge i_clk) begin
            r_cof3[k] <= CFW'(r_pa[k]) - CFW'(r_pb[k]);
            r_cof4[k] <= r_cof3[k];
            r_cof5[k] <= r_cof4[k];
            r_cof6[k] <= r_cof5[k];
        end
    end

    // Stages 4 to 6: determinant along the first row. Each element-times-cofactor
    // product is split into a low half (unsigned) and a high half (signed) so that
    // no multiplier exceeds about 32 by 33 bits, then recombined and summed.
    logic signed [LW-1:0] r_lo [3];
    logic signed [LW-1:0] r_hi [3];
    logic signed [DW-1:0] r_term [3];
    logic signed [DW-1:0] r_det;

    for (genvar i = 0; i < 3; i++) begin : g_det
        logic [CFW-1:0] w_c;

        assign w_c = r_cof3[3*i];

        always_ff @(posedge i_clk) begin
            r_row2[i] <= r_e[i];
            r_row3[i] <= r_row2[i];
            r_lo[i]   <= LW'(r_row3[i]) * LW'($signed({1'b0, w_c[E-1:0]}));
            r_hi[i]   <= LW'(r_row3[i]) * LW'($signed(w_c[CFW-1:E]));
            r_term[i] <= (DW'(r_hi[i]) <<< E) + DW'(r_lo[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_det <= r_term[0] + r_term[1] + r_term[2];
    end

    // Stage 7: magnitudes for the dividers. The numerator is the cofactor
    // scaled by two fraction widths so the quotient lands back at Q format.
    logic [DW-1:0] w_dmag;
    logic [CW-1:0] r_num [9];
    logic [CW-1:0] r_den [9];
    logic [8:0]    r_neg;
    logic          r_zero;

    assign w_dmag = r_det[DW-1] ? DW'(-r_det) : DW'(r_det);

    for (genvar k = 0; k < 9; k++) begin : g_mag
        logic [CFW-1:0] w_cmag;

        assign w_cmag = r_cof6[k][CFW-1] ? CFW'(-r_cof6[k]) : CFW'(r_cof6[k]);

        always_ff @(posedge i_clk) begin
            r_num[k] <= CW'(w_cmag) << (2 * FRAC_BITS);
            r_den[k] <= CW'(w_dmag);
            r_neg[k] <= r_cof6[k][CFW-1] ^ r_det[DW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero <= (r_det == '0);
    end

    // Dividers: E + 1 stages each. Signs and the singular flag ride alongside.
    logic [E-1:0] w_q   [9];
    logic [8:0]   w_big;
    logic [8:0]   r_dneg  [E+1];
    logic         r_dzero [E+1];

    for (genvar k = 0; k < 9; k++) begin : g_div
        m3inv_div #(
            .QW (E),
            .CW (CW)
        ) u_div (
            .i_clk (i_clk),
            .i_num (r_num[k]),
            .i_den (r_den[k]),
            .o_q   (w_q[k]),
            .o_big (w_big[k])
        );
    end

    always_ff @(posedge i_clk) begin
        r_dneg[0]  <= r_neg;
        r_dzero[0] <= r_zero;
    end

    for (genvar j = 1; j <= E; j++) begin : g_dly
        always_ff @(posedge i_clk) begin
            r_dneg[j]  <= r_dneg[j-1];
            r_dzero[j] <= r_dzero[j-1];
        end
    end

    // Final stage: apply the sign and saturate. A positive quotient saturates
    // once its top bit is set; a negative one only beyond the most negative value.
    // A singular matrix forces every element to zero.
    logic [E-1:0] r_res [9];
    logic         r_sing;

    for (genvar k = 0; k < 9; k++) begin : g_out
        logic [E-1:0] w_val;

        always_comb begin
            if (r_dneg[E][k]) begin
                if (w_big[k] || (w_q[k][E-1] && (|w_q[k][E-2:0]))) begin
                    w_val = {1'b1, {(E-1){1'b0}}};
                end else begin
                    w_val = E'(-w_q[k]);
                end
            end else begin
                if (w_big[k] || w_q[k][E-1]) begin
                    w_val = {1'b0, {(E-1){1'b1}}};
                end else begin
                    w_val = w_q[k];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_res[k] <= r_dzero[E] ? '0 : w_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sing <= r_dzero[E];
    end

    assign o_result.b00      = r_res[0];
    assign o_result.b01      = r_res[1];
    assign o_result.b02      = r_res[2];
    assign o_result.b10      = r_res[3];
    assign o_result.b11      = r_res[4];
    assign o_result.b12      = r_res[5];
    assign o_result.b20      = r_res[6];
    assign o_result.b21      = r_res[7];
    assign o_result.b22      = r_res[8];
    assign o_result.singular = r_sing;

endmodule

@@ tb/tb_matrix3_inverse_core.sv @@
`timescale 1ns / 1ps

module tb_matrix3_inverse_core;
    import m3inv_pkg::*;

    // The core is fully pipelined, so the drain at the end waits comfortably longer
    // than its pipeline depth, which LATENCY stands for.
    localparam int LATENCY       = ELEM_WIDTH + 9;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int MAX_REPORTS   = 10;
    localparam int WIDE          = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_matrix_in  i_matrix;
    logic        o_valid;
    t_matrix_out o_result;

    t_matrix_out inverse_queue[$];
    int          mismatch_count;
    int          idle_cycles;
    bit          no_gaps;
    bit          timed_out;

    matrix3_inverse_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_matrix(i_matrix),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Saturate an exact signed quotient to the element range.
    function automatic logic signed [ELEM_WIDTH-1:0] saturate_elem(
        input logic signed [WIDE-1:0] q
    );
        logic signed [WIDE-1:0] hi;
        logic signed [WIDE-1:0] lo;
        begin
            hi = (WIDE'(1) <<< (ELEM_WIDTH - 1)) - 1;
            lo = -(WIDE'(1) <<< (ELEM_WIDTH - 1));
            if (q > hi) begin
                return hi[ELEM_WIDTH-1:0];
            end else if (q < lo) begin
                return lo[ELEM_WIDTH-1:0];
            end
            return q[ELEM_WIDTH-1:0];
        end
    endfunction

    // Adjugate over determinant, computed exactly in wide signed arithmetic.
    // SystemVerilog signed division truncates toward zero, as the core does.
    function automatic t_matrix_out predict_inverse(input t_matrix_in m);
        logic signed [WIDE-1:0] e [9];
        logic signed [WIDE-1:0] cof [9];
        logic signed [WIDE-1:0] det;
        logic signed [WIDE-1:0] el [9];
        logic signed [ELEM_WIDTH-1:0] r [9];
        t_matrix_out res;
        begin
            e[0] = m.a00; e[1] = m.a01; e[2] = m.a02;
            e[3] = m.a10; e[4] = m.a11; e[5] = m.a12;
            e[6] = m.a20; e[7] = m.a21; e[8] = m.a22;
            // Transposed cofactors, listed in result order.
            cof[0] = e[4] * e[8] - e[5] * e[7];
            cof[1] = e[2] * e[7] - e[1] * e[8];
            cof[2] = e[1] * e[5] - e[2] * e[4];
            cof[3] = e[5] * e[6] - e[3] * e[8];
            cof[4] = e[0] * e[8] - e[2] * e[6];
            cof[5] = e[2] * e[3] - e[0] * e[5];
            cof[6] = e[3] * e[7] - e[4] * e[6];
            cof[7] = e[1] * e[6] - e[0] * e[7];
            cof[8] = e[0] * e[4] - e[1] * e[3];
            det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
            res = '0;
            if (det == 0) begin
                res.singular = 1'b1;
                return res;
            end
            for (int k = 0; k < 9; k++) begin
                el[k] = (cof[k] <<< (2 * FRAC_BITS_DEF)) / det;
                r[k] = saturate_elem(el[k]);
            end
            res.b00 = r[0]; res.b01 = r[1]; res.b02 = r[2];
            res.b10 = r[3]; res.b11 = r[4]; res.b12 = r[5];
            res.b20 = r[6]; res.b21 = r[7]; res.b22 = r[8];
            return res;
        end
    endfunction

    // Send one matrix: optional random gap, then hold start until the core takes it.
    // Start is left high afterwards so the next beat can follow without a gap.
    task automatic send_matrix(input t_matrix_in m);
        begin
            if (!no_gaps) begin
                while ($urandom_range(99) < 15) begin
                    start <= 1'b0;
                    @(posedge i_clk);
                end
            end
            start    <= 1'b1;
            i_matrix <= m;
            inverse_queue.push_back(predict_inverse(m));
            @(posedge i_clk);
            while (busy) begin
                @(posedge i_clk);
            end
        end
    endtask

    function automatic t_matrix_in diag_matrix(input logic [ELEM_WIDTH-1:0] d0,
                                               input logic [ELEM_WIDTH-1:0] d1,
                                               input logic [ELEM_WIDTH-1:0] d2);
        t_matrix_in m;
        begin
            m = '0;
            m.a00 = d0;
            m.a11 = d1;
            m.a22 = d2;
            return m;
        end
    endfunction

    // Random element: mostly modest Q16.16 values, sometimes full range or edges.
    function automatic logic [ELEM_WIDTH-1:0] random_elem();
        int sel;
        begin
            sel = $urandom_range(9);
            case (sel)
                0: begin
                    return $urandom();
                end
                1: begin
                    return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
                end
                2: begin
                    return 32'($signed($urandom_range(8)) - 4);
                end
                3: begin
                    return 32'($signed($urandom_range(16)) - 8) <<< 16;
                end
                default: begin
                    return 32'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
                end
            endcase
        end
    endfunction

    function automatic t_matrix_in random_matrix();
        t_matrix_in m;
        begin
            m = {random_elem(), random_elem(), random_elem(),
                 random_elem(), random_elem(), random_elem(),
                 random_elem(), random_elem(), random_elem()};
            // Every so often force a singular matrix by copying one row into another.
            if ($urandom_range(9) == 0) begin
                m.a20 = m.a00;
                m.a21 = m.a01;
                m.a22 = m.a02;
            end
            return m;
        end
    endfunction

    task automatic test_identity_and_scaling();
        begin
            send_matrix(diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
            send_matrix(diag_matrix(32'h0002_0000, 32'hFFFC_0000, 32'h0000_8000));
            send_matrix(diag_matrix(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
            send_matrix(diag_matrix(32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000));
        end
    endtask

    task automatic test_extremes();
        begin
            send_matrix(diag_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
            send_matrix(diag_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
            send_matrix(diag_matrix(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001));
            send_matrix({9{32'hFFFF_FFFF}});
            send_matrix({32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                         32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF});
            send_matrix({32'hAAAA_AAAA, 32'h5555_5555, 32'h0001_0000,
                         32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000,
                         32'h0001_0000, 32'h0000_0000, 32'h5555_5555});
        end
    endtask

    // Zero determinant in several forms, a tiny determinant that saturates, and two non-singular matrices.
    task automatic test_singular_and_saturation();
        begin
            send_matrix('0);
            send_matrix({9{32'h0001_0000}});
            send_matrix(diag_matrix(32'h0001_0000, 32'h0000_0000, 32'h0001_0000));
            send_matrix({32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                         32'h0004_0000, 32'h0005_0000, 32'h0006_0000,
                         32'h0007_0000, 32'h0008_0000, 32'h0009_0000});
            send_matrix({32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                         32'h0004_0000, 32'h0005_0000, 32'h0006_0000,
                         32'h0007_0000, 32'h0008_0000, 32'h000A_0000});
            send_matrix({32'h0001_0000, 32'h0001_0000, 32'h0000_0000,
                         32'h0001_0000, 32'h0001_0001, 32'h0000_0000,
                         32'h0000_0000, 32'h0000_0000, 32'h0001_0000});
            send_matrix({32'h0000_0000, 32'h0001_0000, 32'h0000_0000,
                         32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
                         32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000});
        end
    endtask

    task automatic test_random(input int count);
        begin
            for (int n = 0; n < count; n++) begin
                // A long burst with no gaps in the middle of the run.
                no_gaps = (n >= count / 3) && (n < count / 3 + 80);
                send_matrix(random_matrix());
            end
            no_gaps = 1'b0;
        end
    endtask

    // Each strobed result is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (inverse_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("ERROR: unexpected result beat %h", o_result);
                end
            end else begin
                t_matrix_out want;
                want = inverse_queue.pop_front();
                if (o_result !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("ERROR: result mismatch");
                        $display("  expected b=%h %h %h %h %h %h %h %h %h singular=%b",
                                 want.b00, want.b01, want.b02, want.b10, want.b11,
                                 want.b12, want.b20, want.b21, want.b22, want.singular);
                        $display("  actual   b=%h %h %h %h %h %h %h %h %h singular=%b",
                                 o_result.b00, o_result.b01, o_result.b02, o_result.b10,
                                 o_result.b11, o_result.b12, o_result.b20, o_result.b21,
                                 o_result.b22, o_result.singular);
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither side moves a beat.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_MAX) begin
            timed_out = 1'b1;
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int drain;
        mismatch_count = 0;
        idle_cycles    = 0;
        no_gaps        = 1'b0;
        timed_out      = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_matrix       = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_identity_and_scaling();
        test_extremes();
        test_singular_and_saturation();
        test_random(400);
        start <= 1'b0;

        // Wait for the pipeline to empty, then a little longer for stray beats.
        drain = 0;
        while (inverse_queue.size() != 0 && drain < 50 * LATENCY) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (2 * LATENCY) @(posedge i_clk);

        if (mismatch_count == 0 && inverse_queue.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/m3inv_pkg.sv
design/m3inv_div.sv
design/matrix3_inverse_core.sv
tb/tb_matrix3_inverse_core.sv
